// ===== hdl/tclc_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-channel lux calculator: shared package
// Item types, segment codes, Q24 coefficients and the elaboration-time
// function that builds the entries of the ratio power table.
// ----------------------------------------------------------------------------
package tclc_pkg;

  // Default sizes handed to the top level.
  localparam int POW_TABLE_DEPTH_DEF = 256;
  localparam int LUX_FRAC_BITS_DEF   = 16;

  // Coefficients are stored with this many fraction bits.
  localparam int COEF_FRAC = 24;
  localparam int COEF_W    = 20;

  localparam logic [COEF_W-1:0] K_S0_B   = 20'd510027;
  localparam logic [COEF_W-1:0] K_S0_POW = 20'd1040187;
  localparam logic [COEF_W-1:0] K_S1_B   = 20'd375810;
  localparam logic [COEF_W-1:0] K_S1_I   = 20'd520094;
  localparam logic [COEF_W-1:0] K_S2_B   = 20'd214748;
  localparam logic [COEF_W-1:0] K_S2_I   = 20'd256691;
  localparam logic [COEF_W-1:0] K_S3_B   = 20'd24495;
  localparam logic [COEF_W-1:0] K_S3_I   = 20'd18790;

  localparam logic [26:0] LUX_MAX = 27'h7FF_FFFF;

  // Segment codes.
  localparam logic [2:0] SEG_LOW  = 3'd0;
  localparam logic [2:0] SEG_MID  = 3'd1;
  localparam logic [2:0] SEG_HIGH = 3'd2;
  localparam logic [2:0] SEG_TOP  = 3'd3;
  localparam logic [2:0] SEG_NONE = 3'd4;

  typedef struct packed {
    logic [15:0] broadband_count;
    logic [15:0] infrared_count;
  } sample_t;

  typedef struct packed {
    logic [26:0] lux_value;
    logic [2:0]  segment;
  } result_t;

  // Table entry for a ratio given in Q30: x^1.4 in Q16. The fifth root of
  // x^2 is found by a binary search, giving x^0.4 in Q12.
  function automatic logic [15:0] pow_entry(input logic [63:0] xq);
    logic [63:0] sq;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    logic [63:0] prod;
    sq = xq * xq;
    lo = 64'd0;
    hi = 64'd4096;
    for (int n = 0; n < 14; n++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        p   = mid * mid * mid * mid * mid;
        if (p <= sq) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    prod = (xq * lo) >> 26;
    return prod[15:0];
  endfunction

endpackage

// ===== hdl/two_channel_lux_calculator_core.sv =====
// ----------------------------------------------------------------------------
// Two-channel lux calculator
// Turns a broadband / infrared photodiode count pair into lux in fixed point.
// ----------------------------------------------------------------------------
// Usage
//   The sample channel carries one item per pair of counts; the result channel
//   returns one item per sample, in order, holding lux_value (LUX_FRAC_BITS
//   fraction bits, clamped at zero, saturated at the field width) and the
//   ratio segment that was used (segment 4 means out of range or a zero
//   broadband count, with zero lux).
//   Both channels use valid and stall; an item moves when valid is high and
//   stall is low at a rising edge.
//   The ratio index comes from a restoring divider with one stage for each
//   quotient bit, and that chain sets the latency. Throughput is one item
//   per cycle while the receiver does not stall: every stage is registered
//   and the whole pipeline moves together.
//   When the receiver stalls a waiting result, the pipeline freezes and
//   sample_stall is raised in the same cycle, so nothing is lost or repeated.
//   Reset is synchronous and clears only the valid bits; the power table is a
//   constant and needs no loading.
// ----------------------------------------------------------------------------
module two_channel_lux_calculator_core #(
  parameter int POW_TABLE_DEPTH = tclc_pkg::POW_TABLE_DEPTH_DEF,
  parameter int LUX_FRAC_BITS   = tclc_pkg::LUX_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  tclc_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_stall,
  output tclc_pkg::result_t result
);

  // Quotient width of the ratio index, and the numerator width of the divider.
  localparam int QB    = $clog2(POW_TABLE_DEPTH);
  localparam int NUM_K = 4 * (POW_TABLE_DEPTH - 1);
  localparam int NW    = 16 + $clog2(NUM_K + 1);
  localparam int SH    = tclc_pkg::COEF_FRAC - LUX_FRAC_BITS;

  localparam logic [63:0]   POW_M   = 64'(2 * (POW_TABLE_DEPTH - 1));
  localparam logic [QB-1:0] IDX_MAX = QB'(POW_TABLE_DEPTH - 1);

  // The whole pipeline advances unless a finished result is being held back.
  logic adv;
  assign adv          = !(result_valid && result_stall);
  assign sample_stall = !adv;

  // --------------------------------------------------------------------------
  // Power table: entry k stands for the ratio k / (2*(depth-1)), raised to
  // the power 1.4, in Q16. The entries are worked out at elaboration.
  // --------------------------------------------------------------------------
  logic [15:0] pow_rom [POW_TABLE_DEPTH];

  for (genvar k = 0; k < POW_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] XQ = (64'(k) << 30) / POW_M;
    assign pow_rom[k] = tclc_pkg::pow_entry(XQ);
  end

  // --------------------------------------------------------------------------
  // Stage 0: segment decision by exact cross products, and the numerator of
  // the ratio index, 4*(depth-1)*I + B, for rounding to nearest.
  // --------------------------------------------------------------------------
  logic          d_valid [QB+1];
  logic [NW-1:0] d_rem   [QB+1];
  logic [QB-1:0] d_quo   [QB+1];
  logic [15:0]   d_b     [QB+1];
  logic [15:0]   d_ir    [QB+1];
  logic [2:0]    d_seg   [QB+1];

  logic [15:0]   in_b;
  logic [15:0]   in_ir;
  logic [2:0]    seg_next;
  logic [NW-1:0] num_next;

  assign in_b  = sample.broadband_count;
  assign in_ir = sample.infrared_count;

  always_comb begin
    if (in_b == 16'd0) begin
      seg_next = tclc_pkg::SEG_NONE;
    end else if ({in_ir, 1'b0} <= {1'b0, in_b}) begin
      seg_next = tclc_pkg::SEG_LOW;
    end else if ((23'(in_ir) * 23'd100) <= (23'(in_b) * 23'd61)) begin
      seg_next = tclc_pkg::SEG_MID;
    end else if ((19'(in_ir) * 19'd5) <= (19'(in_b) * 19'd4)) begin
      seg_next = tclc_pkg::SEG_HIGH;
    end else if ((20'(in_ir) * 20'd10) <= (20'(in_b) * 20'd13)) begin
      seg_next = tclc_pkg::SEG_TOP;
    end else begin
      seg_next = tclc_pkg::SEG_NONE;
    end
  end

  assign num_next = NW'(in_ir) * NW'(NUM_K) + NW'(in_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (adv) begin
      d_valid[0] <= sample_valid;
    end
    if (adv) begin
      d_rem[0] <= num_next;
      d_quo[0] <= '0;
      d_b[0]   <= in_b;
      d_ir[0]  <= in_ir;
      d_seg[0] <= seg_next;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider by 2*B, one quotient bit per stage, most significant
  // first. In the lowest segment the quotient never exceeds depth-1; for the
  // other segments it is not used, and a zero divisor only gives ones.
  // --------------------------------------------------------------------------
  for (genvar s = 1; s <= QB; s++) begin : g_div
    localparam int J = QB - s;
    logic [NW-1:0] dsh;
    logic          ge;

    assign dsh = NW'({d_b[s-1], 1'b0}) << J;
    assign ge  = d_rem[s-1] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[s] <= 1'b0;
      end else if (adv) begin
        d_valid[s] <= d_valid[s-1];
      end
      if (adv) begin
        d_rem[s] <= ge ? (d_rem[s-1] - dsh) : d_rem[s-1];
        d_quo[s] <= d_quo[s-1] | (ge ? (QB'(1) << J) : '0);
        d_b[s]   <= d_b[s-1];
        d_ir[s]  <= d_ir[s-1];
        d_seg[s] <= d_seg[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Table read, plus the two coefficient products of the chosen segment.
  // --------------------------------------------------------------------------
  logic [QB-1:0]                 idx;
  logic [tclc_pkg::COEF_W-1:0]   ka;
  logic [tclc_pkg::COEF_W-1:0]   kb;

  assign idx = (d_quo[QB] > IDX_MAX) ? IDX_MAX : d_quo[QB];

  always_comb begin
    case (d_seg[QB])
      tclc_pkg::SEG_LOW: begin
        ka = tclc_pkg::K_S0_B;
        kb = '0;
      end
      tclc_pkg::SEG_MID: begin
        ka = tclc_pkg::K_S1_B;
        kb = tclc_pkg::K_S1_I;
      end
      tclc_pkg::SEG_HIGH: begin
        ka = tclc_pkg::K_S2_B;
        kb = tclc_pkg::K_S2_I;
      end
      tclc_pkg::SEG_TOP: begin
        ka = tclc_pkg::K_S3_B;
        kb = tclc_pkg::K_S3_I;
      end
      default: begin
        ka = '0;
        kb = '0;
      end
    endcase
  end

  logic        r_valid;
  logic [15:0] r_entry;
  logic [15:0] r_b;
  logic [2:0]  r_seg;
  logic [35:0] r_pa;
  logic [35:0] r_pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (adv) begin
      r_valid <= d_valid[QB];
    end
    if (adv) begin
      r_entry <= pow_rom[idx];
      r_b     <= d_b[QB];
      r_seg   <= d_seg[QB];
      r_pa    <= 36'(ka) * 36'(d_b[QB]);
      r_pb    <= 36'(kb) * 36'(d_ir[QB]);
    end
  end

  // --------------------------------------------------------------------------
  // Lowest segment: B times the table entry, then times the power coefficient.
  // --------------------------------------------------------------------------
  logic        m_valid;
  logic [31:0] m_p1;
  logic [2:0]  m_seg;
  logic [35:0] m_pa;
  logic [35:0] m_pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= r_valid;
    end
    if (adv) begin
      m_p1  <= 32'(r_b) * 32'(r_entry);
      m_seg <= r_seg;
      m_pa  <= r_pa;
      m_pb  <= r_pb;
    end
  end

  logic [51:0] term_full;
  assign term_full = 52'(m_p1) * 52'(tclc_pkg::K_S0_POW);

  logic        t_valid;
  logic [35:0] t_term;
  logic [2:0]  t_seg;
  logic [35:0] t_pa;
  logic [35:0] t_pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (adv) begin
      t_valid <= m_valid;
    end
    if (adv) begin
      t_term <= term_full[51:16];
      t_seg  <= m_seg;
      t_pa   <= m_pa;
      t_pb   <= m_pb;
    end
  end

  // --------------------------------------------------------------------------
  // Difference in Q24, clamped at zero; the out-of-range segment gives zero.
  // --------------------------------------------------------------------------
  logic [36:0] diff;
  assign diff = {1'b0, t_pa} -
                {1'b0, ((t_seg == tclc_pkg::SEG_LOW) ? t_term : t_pb)};

  logic        s_valid;
  logic [35:0] s_q;
  logic [2:0]  s_seg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (adv) begin
      s_valid <= t_valid;
    end
    if (adv) begin
      s_q   <= ((t_seg == tclc_pkg::SEG_NONE) || diff[36]) ? '0 : diff[35:0];
      s_seg <= t_seg;
    end
  end

  // --------------------------------------------------------------------------
  // Rescale to the output fraction width, rounding half up, and saturate.
  // --------------------------------------------------------------------------
  logic [36:0] rnd;

  if (SH > 0) begin : g_round
    localparam logic [36:0] HALF = 37'(1) << (SH - 1);
    assign rnd = (37'(s_q) + HALF) >> SH;
  end else begin : g_noround
    assign rnd = 37'(s_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s_valid;
    end
    if (adv) begin
      result.lux_value <= (rnd > 37'(tclc_pkg::LUX_MAX)) ? tclc_pkg::LUX_MAX : rnd[26:0];
      result.segment   <= s_seg;
    end
  end

endmodule

// ===== hdl/tclc_checker.sv =====
// ----------------------------------------------------------------------------
// Two-channel lux calculator: port checker
// Watches the ports of the calculator core and flags results that break its
// rules; attached to the core by the bind at the end of this file.
// ----------------------------------------------------------------------------
module tclc_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_stall,
  input tclc_pkg::sample_t sample,
  input logic              result_valid,
  input logic              result_stall,
  input tclc_pkg::result_t result
);

  // A held result stays put until it is taken.
  a_hold : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result item changed");

  // The sample side is held back exactly when a finished result waits.
  a_backpressure : assert property (@(posedge clk) disable iff (rst)
    sample_stall == (result_valid && result_stall))
    else $error("sample stall does not follow result stall");

  // Segment codes stop at the out-of-range code.
  a_seg_range : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.segment <= tclc_pkg::SEG_NONE))
    else $error("segment code out of range");

  // The out-of-range segment carries zero lux.
  a_none_zero : assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.segment == tclc_pkg::SEG_NONE)) |-> (result.lux_value == '0))
    else $error("out-of-range segment with nonzero lux");

  // An accepted sample item carries no unknown bits.
  a_sample_known : assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |-> !$isunknown(sample))
    else $error("accepted sample item has unknown bits");

endmodule

bind two_channel_lux_calculator_core tclc_checker u_tclc_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sample       (sample),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== tb/tb_two_channel_lux_calculator_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-channel lux calculator: self-checking testbench
// Feeds broadband / infrared count pairs through the core and compares every
// result item with a behavioural prediction of lux and segment, under random
// idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_two_channel_lux_calculator_core;

  localparam int TABLE_DEPTH = tclc_pkg::POW_TABLE_DEPTH_DEF;
  localparam int LUX_FRAC    = tclc_pkg::LUX_FRAC_BITS_DEF;
  localparam int ROUND_SHIFT = tclc_pkg::COEF_FRAC - LUX_FRAC;
  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 200000;
  // Idling schedule; the phase ends and the hold start are reckoned in accepted sample items.
  localparam int PHASE_A_END  = 380;
  localparam int PHASE_B_END  = 760;
  localparam int HOLD_START   = 850;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  tclc_pkg::sample_t sample = '0;
  logic              result_valid;
  logic              result_stall = 1'b1;
  tclc_pkg::result_t result;

  two_channel_lux_calculator_core uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sample items still to be offered, and lux results still owed by the core.
  tclc_pkg::sample_t sample_q[$];
  tclc_pkg::result_t lux_expect_q[$];
  tclc_pkg::result_t lux_want;

  // Ratio power table: entry k holds (k/M)^1.4 in Q16, with M = 2*(depth-1).
  longint unsigned ratio_pow[TABLE_DEPTH];

  int samples_taken = 0;
  int error_cnt     = 0;
  int cycle_cnt     = 0;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Largest s with s^5 <= v, built one bit at a time from the top. The root
  // of a squared Q30 ratio no larger than one half stays below 2^12.
  function automatic longint unsigned root5_floor(input longint unsigned v);
    longint unsigned s;
    longint unsigned c;
    s = 0;
    for (int bitpos = 11; bitpos >= 0; bitpos--) begin
      c = s | (64'd1 << bitpos);
      if (c * c * c * c * c <= v) begin
        s = c;
      end
    end
    return s;
  endfunction

  function automatic void fill_ratio_pow();
    longint unsigned m;
    longint unsigned xq;
    m = 2 * (TABLE_DEPTH - 1);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      xq = (longint'(k) << 30) / m;
      ratio_pow[k] = (xq * root5_floor(xq * xq)) >> 26;
    end
  endfunction

  // Expected lux and segment for one pair of counts. The segment limits are
  // tested with exact cross products, always taking the lower segment on a tie.
  function automatic tclc_pkg::result_t compute_lux(input tclc_pkg::sample_t s);
    longint unsigned   b;
    longint unsigned   ir;
    longint unsigned   idx;
    longint unsigned   term;
    longint unsigned   lux;
    longint            q24;
    tclc_pkg::result_t r;
    b   = s.broadband_count;
    ir  = s.infrared_count;
    q24 = 0;
    if (b == 0) begin
      // No broadband light: nothing to divide by, the answer is simply zero.
      r.segment = tclc_pkg::SEG_NONE;
    end else if (2 * ir <= b) begin
      idx = (4 * (TABLE_DEPTH - 1) * ir + b) / (2 * b);
      if (idx > TABLE_DEPTH - 1) begin
        idx = TABLE_DEPTH - 1;
      end
      term = (tclc_pkg::K_S0_POW * b * ratio_pow[idx]) >> 16;
      q24 = longint'(tclc_pkg::K_S0_B * b) - longint'(term);
      r.segment = tclc_pkg::SEG_LOW;
    end else if (100 * ir <= 61 * b) begin
      q24 = longint'(tclc_pkg::K_S1_B * b) - longint'(tclc_pkg::K_S1_I * ir);
      r.segment = tclc_pkg::SEG_MID;
    end else if (5 * ir <= 4 * b) begin
      q24 = longint'(tclc_pkg::K_S2_B * b) - longint'(tclc_pkg::K_S2_I * ir);
      r.segment = tclc_pkg::SEG_HIGH;
    end else if (10 * ir <= 13 * b) begin
      q24 = longint'(tclc_pkg::K_S3_B * b) - longint'(tclc_pkg::K_S3_I * ir);
      r.segment = tclc_pkg::SEG_TOP;
    end else begin
      r.segment = tclc_pkg::SEG_NONE;
    end
    if (q24 < 0) begin
      q24 = 0;
    end
    // Drop from Q24 to the output format, rounding half up, then saturate.
    lux = (longint'(q24) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    if (lux > tclc_pkg::LUX_MAX) begin
      lux = tclc_pkg::LUX_MAX;
    end
    r.lux_value = lux[26:0];
    return r;
  endfunction

  function automatic void queue_sample(input int unsigned b, input int unsigned ir);
    tclc_pkg::sample_t s;
    s.broadband_count = b[15:0];
    s.infrared_count  = ir[15:0];
    sample_q.push_back(s);
  endfunction

  // A random item, weighted towards the segment limits and the special cases
  // so that every segment and each tie is reached many times.
  function automatic void queue_random_sample();
    int unsigned b;
    int          ir;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       b = $urandom_range(1, 255);
      1:       b = $urandom_range(60000, 65535);
      default: b = $urandom_range(1, 65535);
    endcase
    if (pick < 20) begin
      b  = $urandom_range(0, 65535);
      ir = $urandom_range(0, 65535);
    end else if (pick < 65) begin
      // Ratio drawn evenly over all segments, in thousandths.
      ir = (b * $urandom_range(0, 1500)) / 1000;
    end else if (pick < 85) begin
      // Just either side of, or exactly on, one of the four limits.
      case ($urandom_range(0, 3))
        0:       ir = b / 2;
        1:       ir = (61 * b) / 100;
        2:       ir = (4 * b) / 5;
        default: ir = (13 * b) / 10;
      endcase
      ir = ir + $urandom_range(0, 4) - 2;
    end else if (pick < 95) begin
      // Zero broadband or zero infrared.
      ir = $urandom_range(0, 65535);
      if (pick < 90) begin
        b = 0;
      end else begin
        ir = 0;
      end
    end else begin
      b  = $urandom_range(0, 1) ? 65535 : $urandom_range(65000, 65535);
      ir = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 65535);
    end
    if (ir < 0) begin
      ir = 0;
    end else if (ir > 65535) begin
      ir = 65535;
    end
    queue_sample(b, ir);
  endfunction

  // First the receiver is the slower side, then the sender, then both run
  // flat out so that the core is exercised at full rate.
  always_comb begin
    if (samples_taken < PHASE_A_END) begin
      send_idle_pct = 32;
      recv_idle_pct = 73;
    end else if (samples_taken < PHASE_B_END) begin
      send_idle_pct = 73;
      recv_idle_pct = 32;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // Sample driver. The payload and valid hold while the core stalls; a new
  // item is only put up once the current one has been taken. The expected
  // result is recorded at the edge where the core accepts the item.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || !sample_stall) begin
      if (sample_valid) begin
        lux_expect_q.push_back(compute_lux(sample));
        samples_taken <= samples_taken + 1;
      end
      if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        sample       <= sample_q.pop_front();
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Result stall. Once, well into the run, the receiver holds off for a long
  // stretch while the sender keeps offering items, so that the pipeline fills
  // and the core has to stall its input.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b1;
    end else if (!hold_done && samples_taken >= HOLD_START) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result monitor: each accepted result item is checked against the oldest
  // outstanding expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (lux_expect_q.size() == 0) begin
        if (error_cnt < REPORT_MAX) begin
          $display("%0t: result with nothing expected: lux %0d segment %0d",
                   $realtime, result.lux_value, result.segment);
        end
        error_cnt <= error_cnt + 1;
      end else begin
        lux_want = lux_expect_q.pop_front();
        if (result.lux_value !== lux_want.lux_value ||
            result.segment !== lux_want.segment) begin
          if (error_cnt < REPORT_MAX) begin
            $display("%0t: mismatch: expected lux %0d segment %0d, got lux %0d segment %0d",
                     $realtime, lux_want.lux_value, lux_want.segment,
                     result.lux_value, result.segment);
          end
          error_cnt <= error_cnt + 1;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("two_channel_lux_calculator_core test failed");
      $finish;
    end
  end

  initial begin
    fill_ratio_pow();

    // Directed items: field extremes, both special cases, every segment and
    // the pairs that sit exactly on each limit or just above it.
    queue_sample(0, 0);
    queue_sample(0, 65535);
    queue_sample(65535, 0);
    queue_sample(1, 0);
    queue_sample(65535, 65535);
    queue_sample(1, 1);
    queue_sample(2, 1);
    queue_sample(65535, 32767);
    queue_sample(65534, 32767);
    queue_sample(1000, 1);
    queue_sample(100, 61);
    queue_sample(100, 62);
    queue_sample(5, 4);
    queue_sample(50, 41);
    queue_sample(10, 13);
    queue_sample(10, 14);
    queue_sample(40000, 30000);
    queue_sample(21845, 43690);
    queue_sample(43690, 21845);
    queue_sample(3, 1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      queue_random_sample();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken, then for every result to come back,
    // then a while longer in case the core produces anything extra.
    while (sample_q.size() != 0 || sample_valid) begin
      @(posedge clk);
    end
    while (lux_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_cnt == 0 && lux_expect_q.size() == 0) begin
      $display("two_channel_lux_calculator_core test passed");
    end else begin
      $display("two_channel_lux_calculator_core test failed");
    end
    $finish;
  end

endmodule

// ===== two_channel_lux_calculator_core.f =====
hdl/tclc_pkg.sv
hdl/two_channel_lux_calculator_core.sv
hdl/tclc_checker.sv
tb/tb_two_channel_lux_calculator_core.sv
